// File: rtl/fqmd_pkg.sv
package fqmd_pkg;

    // Operand / fraction geometry
    localparam int FRAC_BITS = 16;
    localparam int DW        = 64;
    localparam int HW        = DW / 2;
    localparam int PW        = 2 * DW;
    // Quotient width of |a| * 2^(FRAC_BITS+1) / |b|
    localparam int QW        = DW + FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(QW);

    localparam logic [DW-1:0]    SMAX     = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]    SMIN     = {1'b1, {(DW-1){1'b0}}};
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW - 1);

    // Operation codes
    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_DIV = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MNEG,
        ST_MRND,
        ST_DIV,
        ST_DRND,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul_pp;
        logic       mul_acc;
        logic [1:0] pp_idx;
        logic       mul_neg;
        logic       mul_rnd;
        logic       div_step;
        logic       div_rnd;
        logic       out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_div;
        logic in_bzero;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/fqmd_in_if.sv
interface fqmd_in_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [fqmd_pkg::DW-1:0]   operand_a;
    logic signed [fqmd_pkg::DW-1:0]   operand_b;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input mode, input operand_a, input operand_b,
                    output ready);
endinterface

// File: rtl/fqmd_out_if.sv
interface fqmd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [fqmd_pkg::DW-1:0]   result;
    logic                             overflow;
    logic                             divide_by_zero;

    modport source (output valid, output result, output overflow, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input result, input overflow, input divide_by_zero,
                    output ready);
endinterface

// File: rtl/fixed_q48_16_mul_div_unit.sv
// Signed 48.16 multiply / divide with saturation; multiply rounds half up, divide rounds the magnitude half up.
// Multiply: 4 32x32 partial products, then a sign step and a rounding step.
// Divide: radix-2 restoring divider, one quotient bit of 81 per cycle.
// Zero divisor: no divide iterations. One operation at a time; a new beat is taken while a result waits.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module fixed_q48_16_mul_div_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fqmd_in_if.sink     i_in,
    fqmd_out_if.source  o_out
);

    fqmd_pkg::t_cmd   cmd;
    fqmd_pkg::t_sts   sts;
    logic             in_ready;
    logic             out_valid;
    logic [fqmd_pkg::DW-1:0] out_result;
    logic             out_ovf;
    logic             out_dz;

    fqmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fqmd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_in.mode),
        .i_operand_a      (i_in.operand_a),
        .i_operand_b      (i_in.operand_b),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (out_valid),
        .o_result         (out_result),
        .o_overflow       (out_ovf),
        .o_divide_by_zero (out_dz)
    );

    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.result         = out_result;
    assign o_out.overflow       = out_ovf;
    assign o_out.divide_by_zero = out_dz;

endmodule

// File: rtl/fqmd_ctrl.sv
module fqmd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fqmd_pkg::t_sts   i_sts,
    output fqmd_pkg::t_cmd   o_cmd
);

    fqmd_pkg::t_state             r_state, n_state;
    logic [fqmd_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fqmd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Sequencing
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fqmd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    if (i_sts.in_div) begin
                        // zero divisor needs no iterations
                        n_state = i_sts.in_bzero ? fqmd_pkg::ST_DONE : fqmd_pkg::ST_DIV;
                    end else begin
                        n_state = fqmd_pkg::ST_MUL;
                    end
                end
            end
            fqmd_pkg::ST_MUL: begin
                // partial product k is formed while product k-1 is accumulated
                o_cmd.mul_pp  = (r_cnt != fqmd_pkg::MUL_LAST);
                o_cmd.mul_acc = (r_cnt != '0);
                o_cmd.pp_idx  = r_cnt[1:0];
                if (r_cnt == fqmd_pkg::MUL_LAST) begin
                    n_state = fqmd_pkg::ST_MNEG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            fqmd_pkg::ST_MNEG: begin
                o_cmd.mul_neg = 1'b1;
                n_state       = fqmd_pkg::ST_MRND;
            end
            fqmd_pkg::ST_MRND: begin
                o_cmd.mul_rnd = 1'b1;
                n_state       = fqmd_pkg::ST_DONE;
            end
            fqmd_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == fqmd_pkg::DIV_LAST) begin
                    n_state = fqmd_pkg::ST_DRND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            fqmd_pkg::ST_DRND: begin
                o_cmd.div_rnd = 1'b1;
                n_state       = fqmd_pkg::ST_DONE;
            end
            fqmd_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = fqmd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fqmd_pkg::ST_IDLE;
            end
        endcase
    end

    // An accepted beat always starts work
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != fqmd_pkg::ST_IDLE))
        else $error("accepted beat did not start an operation");

    // Divider iteration count stays within the quotient width
    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqmd_pkg::ST_DIV) |-> (r_cnt <= fqmd_pkg::DIV_LAST))
        else $error("divider step counter out of range");

    // Multiply sequence always reaches negate step after the last partial product
    a_mul_to_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqmd_pkg::ST_MUL && r_cnt == fqmd_pkg::MUL_LAST)
        |=> (r_state == fqmd_pkg::ST_MNEG))
        else $error("multiply sequence skipped sign step");

endmodule

// File: rtl/fqmd_dp.sv
module fqmd_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fqmd_pkg::t_cmd                   i_cmd,
    output fqmd_pkg::t_sts                   o_sts,
    input  logic                             i_mode,
    input  logic signed [fqmd_pkg::DW-1:0]   i_operand_a,
    input  logic signed [fqmd_pkg::DW-1:0]   i_operand_b,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [fqmd_pkg::DW-1:0]   o_result,
    output logic                             o_overflow,
    output logic                             o_divide_by_zero
);

    localparam int DW = fqmd_pkg::DW;
    localparam int HW = fqmd_pkg::HW;
    localparam int PW = fqmd_pkg::PW;
    localparam int QW = fqmd_pkg::QW;

    logic            r_mode, r_dz, r_neg;
    logic [DW-1:0]   r_ma, r_mb;
    logic [DW-1:0]   r_pp;
    logic [1:0]      r_pp_idx;
    logic [PW-1:0]   r_acc;
    logic [DW-1:0]   r_rem;
    logic [QW-1:0]   r_nq;
    logic            r_out_vld, r_ovf, r_dzo;
    logic [DW-1:0]   r_result;

    logic [DW-1:0]   mag_a, mag_b;
    logic [HW-1:0]   x_h, y_h;
    logic [DW-1:0]   pp_next;
    logic [PW-1:0]   pp_wide;
    logic [DW:0]     div_shl, div_trial;
    logic            q_bit;
    logic [QW:0]     q_inc;
    logic [PW-1:0]   mul_sh;
    logic            mul_ovf;
    logic [QW-1:0]   div_m;
    logic            div_ovf;
    logic [DW-1:0]   fin_result;
    logic            fin_ovf;
    logic            out_free;

    function automatic logic pp_half_sel(input logic [1:0] idx, input logic hi);
        pp_half_sel = hi ? idx[1] : idx[0];
    endfunction

    // Operand magnitudes (most negative value maps to 2^63)
    assign mag_a = i_operand_a[DW-1] ? (~i_operand_a + 1'b1) : i_operand_a;
    assign mag_b = i_operand_b[DW-1] ? (~i_operand_b + 1'b1) : i_operand_b;

    // 32x32 partial product select from the operand halves
    assign x_h     = pp_half_sel(i_cmd.pp_idx, 1'b0) ? r_ma[DW-1:HW] : r_ma[HW-1:0];
    assign y_h     = pp_half_sel(i_cmd.pp_idx, 1'b1) ? r_mb[DW-1:HW] : r_mb[HW-1:0];
    assign pp_next = DW'(x_h) * DW'(y_h);

    // Place registered partial product by its half-word weights
    always_comb begin
        case (r_pp_idx)
            2'd0:    pp_wide = PW'(r_pp);
            2'd1:    pp_wide = PW'(r_pp) << HW;
            2'd2:    pp_wide = PW'(r_pp) << HW;
            2'd3:    pp_wide = PW'(r_pp) << DW;
            default: pp_wide = PW'(r_pp);
        endcase
    end

    // Restoring divide step
    assign div_shl   = {r_rem, r_nq[QW-1]};
    assign div_trial = div_shl - {1'b0, r_mb};
    assign q_bit     = ~div_trial[DW];

    // Quotient plus one, halved later for round half up
    assign q_inc = {1'b0, r_nq} + (QW+1)'(1);

    // Multiply: arithmetic shift and range check on upper bits
    assign mul_sh  = PW'($signed(r_acc) >>> fqmd_pkg::FRAC_BITS);
    assign mul_ovf = !((&mul_sh[PW-1:DW-1]) || !(|mul_sh[PW-1:DW-1]));

    // Divide: range check on magnitude
    assign div_m   = r_acc[QW-1:0];
    assign div_ovf = r_neg ? ((|div_m[QW-1:DW]) || (div_m[DW-1] && (|div_m[DW-2:0])))
                           : (|div_m[QW-1:DW-1]);

    // Final result selection
    always_comb begin
        fin_result = '0;
        fin_ovf    = 1'b0;
        if (r_dz) begin
            fin_result = '0;
            fin_ovf    = 1'b0;
        end else if (r_mode == fqmd_pkg::MODE_MUL) begin
            fin_ovf    = mul_ovf;
            fin_result = mul_ovf ? (r_acc[PW-1] ? fqmd_pkg::SMIN : fqmd_pkg::SMAX)
                                 : mul_sh[DW-1:0];
        end else begin
            fin_ovf = div_ovf;
            if (div_ovf) begin
                fin_result = r_neg ? fqmd_pkg::SMIN : fqmd_pkg::SMAX;
            end else begin
                fin_result = r_neg ? (~div_m[DW-1:0] + 1'b1) : div_m[DW-1:0];
            end
        end
    end

    // Operand capture and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_dz     <= (i_mode == fqmd_pkg::MODE_DIV) && (i_operand_b == '0);
            r_neg    <= i_operand_a[DW-1] ^ i_operand_b[DW-1];
            r_ma     <= mag_a;
            r_mb     <= mag_b;
            r_acc    <= '0;
            r_rem    <= '0;
            r_nq     <= QW'(mag_a) << (fqmd_pkg::FRAC_BITS + 1);
        end else begin
            if (i_cmd.mul_acc) begin
                r_acc <= r_acc + pp_wide;
            end else if (i_cmd.mul_neg) begin
                if (r_neg) begin
                    r_acc <= ~r_acc + 1'b1;
                end
            end else if (i_cmd.mul_rnd) begin
                r_acc <= r_acc + (PW'(1) << (fqmd_pkg::FRAC_BITS - 1));
            end else if (i_cmd.div_rnd) begin
                r_acc <= PW'(q_inc[QW:1]);
            end
            if (i_cmd.div_step) begin
                r_rem <= q_bit ? div_trial[DW-1:0] : div_shl[DW-1:0];
                r_nq  <= {r_nq[QW-2:0], q_bit};
            end
        end
        if (i_cmd.mul_pp) begin
            r_pp     <= pp_next;
            r_pp_idx <= i_cmd.pp_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result <= fin_result;
            r_ovf    <= fin_ovf;
            r_dzo    <= r_dz;
        end
    end

    assign out_free         = !r_out_vld || i_out_ready;
    assign o_sts.in_div     = (i_mode == fqmd_pkg::MODE_DIV);
    assign o_sts.in_bzero   = (i_operand_b == '0);
    assign o_sts.out_free   = out_free;
    assign o_out_valid      = r_out_vld;
    assign o_result         = r_result;
    assign o_overflow       = r_ovf;
    assign o_divide_by_zero = r_dzo;

    // Zero divisor beat carries a clean zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_dzo) |-> (r_result == '0 && !r_ovf))
        else $error("divide by zero beat with nonzero result");

    // Overflow beat is saturated
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_ovf) |-> (r_result == fqmd_pkg::SMIN || r_result == fqmd_pkg::SMAX))
        else $error("overflow beat not saturated");

    // Output register is only loaded when free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !i_cmd.out_load)
        else $error("pending result overwritten");

endmodule
